[hw/rtl/lsfg_pkg.sv]
// shared constants for the led strip frame generator
// command codes, status codes and the fixed bytes of the strip protocol
// no dependencies
package lsfg_pkg;

   localparam int LenWidth   = 16;
   localparam int ByteWidth  = 8;
   localparam int RunBytes   = 8;
   localparam int RunIdxBits = $clog2(RunBytes);

   typedef logic [LenWidth-1:0]   len_type;
   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [1:0]            status_type;
   typedef logic [RunIdxBits-1:0] run_idx_type;
   typedef byte_type [RunBytes-1:0] run_bytes_type;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_TOO_LONG  = 2'd1;
   localparam status_type STATUS_NO_FRAME  = 2'd2;

   localparam byte_type HDR_BASE       = 8'he0;
   localparam byte_type BRIGHT_MAX     = 8'd31;
   localparam byte_type BRIGHT_DEFAULT = 8'd15;
   localparam byte_type START_BYTE     = 8'h00;
   localparam byte_type END_BYTE       = 8'hff;

   // index of the last byte in a run of one, four or eight bytes
   localparam run_idx_type LAST_OF_ONE   = 3'd0;
   localparam run_idx_type LAST_OF_FOUR  = 3'd3;
   localparam run_idx_type LAST_OF_EIGHT = 3'd7;

endpackage

[hw/rtl/led_strip_frame_generator_core.sv]
// led strip frame generator: turns begin and pixel commands into the byte stream
// of a two-wire addressable led strip, one byte per result transaction
// depends on lsfg_pkg
//
// usage
//   csr_ channel: write led_count (strip length); always ready, write only while idle
//   req_ channel: command 0 opens a frame of frame_length pixels, command 1 is a pixel
//   rsp_ channel: one byte per transaction with status and last_of_run
// a begin gives four 0x00 bytes (plus four 0xff bytes for an empty frame), a pixel gives
// header, blue, green, red (plus four 0xff bytes after the last pixel of the frame).
// errors (frame longer than strip, pixel with no open frame) give one byte 0.
// timing
//   an accepted transaction lands in a one-entry holding register and moves to the output
//   serializer at the next edge where that is free; its first byte shows on rsp_ right then
//   the serializer sends one byte per cycle while rsp_stall is low; the byte serializer sets the rate
//   req_stall rises only when the holding register is full and the serializer busy
// reset clears the frame state, led_count and both stages; no transaction is lost
// while rsp_stall is high, the byte shown holds and the pipeline backs up into req_stall
module led_strip_frame_generator_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lsfg_pkg::len_type     csr_led_count,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  lsfg_pkg::len_type     req_frame_length,
   input  lsfg_pkg::byte_type    req_red,
   input  lsfg_pkg::byte_type    req_green,
   input  lsfg_pkg::byte_type    req_blue,
   input  lsfg_pkg::byte_type    req_brightness,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lsfg_pkg::byte_type    rsp_spi_byte,
   output lsfg_pkg::status_type  rsp_status,
   output logic                  rsp_last_of_run
);
   import lsfg_pkg::*;

   len_type       led_count_ff;
   logic          frame_open_ff, frame_open_in;
   len_type       pixels_left_ff, pixels_left_in;

   logic          pend_valid_ff, pend_valid_in;
   run_bytes_type pend_bytes_ff, pend_bytes_in;
   run_idx_type   pend_last_ff, pend_last_in;
   status_type    pend_status_ff, pend_status_in;

   logic          run_valid_ff, run_valid_in;
   run_bytes_type run_bytes_ff, run_bytes_in;
   run_idx_type   run_left_ff, run_left_in;
   status_type    run_status_ff, run_status_in;

   logic          req_take;
   logic          rsp_take;
   logic          run_done;
   logic          run_free;
   logic          run_load;
   byte_type      hdr_byte;

   assign csr_ready = 1'b1;
   assign rsp_take  = run_valid_ff && !rsp_stall;
   assign run_done  = rsp_take && (run_left_ff == LAST_OF_ONE);
   assign run_free  = !run_valid_ff || run_done;
   assign run_load  = pend_valid_ff && run_free;
   assign req_stall = pend_valid_ff && !run_free;
   assign req_take  = req_valid && !req_stall;

   assign hdr_byte = HDR_BASE |
                     ((req_brightness > BRIGHT_MAX) ? BRIGHT_DEFAULT : req_brightness);

   // build the whole byte run of the incoming transaction
   always_comb begin
      frame_open_in  = frame_open_ff;
      pixels_left_in = pixels_left_ff;
      pend_bytes_in  = pend_bytes_ff;
      pend_last_in   = pend_last_ff;
      pend_status_in = pend_status_ff;
      pend_valid_in  = pend_valid_ff && !run_load;
      if (req_take) begin
         pend_valid_in  = 1'b1;
         pend_status_in = STATUS_OK;
         pend_last_in   = LAST_OF_FOUR;
         for (int i = 0; i < RunBytes; i++) begin
            pend_bytes_in[i] = (i < 4) ? START_BYTE : END_BYTE;
         end
         unique case (req_command)
            CMD_BEGIN: begin
               frame_open_in  = 1'b0;
               pixels_left_in = '0;
               if (req_frame_length > led_count_ff) begin
                  pend_status_in   = STATUS_TOO_LONG;
                  pend_last_in     = LAST_OF_ONE;
                  pend_bytes_in[0] = START_BYTE;
               end else if (req_frame_length == '0) begin
                  pend_last_in = LAST_OF_EIGHT;
               end else begin
                  frame_open_in  = 1'b1;
                  pixels_left_in = req_frame_length;
               end
            end
            CMD_PIXEL: begin
               if (!frame_open_ff) begin
                  pend_status_in   = STATUS_NO_FRAME;
                  pend_last_in     = LAST_OF_ONE;
                  pend_bytes_in[0] = START_BYTE;
               end else begin
                  pend_bytes_in[0] = hdr_byte;
                  pend_bytes_in[1] = req_blue;
                  pend_bytes_in[2] = req_green;
                  pend_bytes_in[3] = req_red;
                  pixels_left_in   = pixels_left_ff - len_type'(1);
                  if (pixels_left_ff == len_type'(1)) begin
                     frame_open_in = 1'b0;
                     pend_last_in  = LAST_OF_EIGHT;
                  end
               end
            end
            default: begin
               pend_valid_in = pend_valid_ff;
            end
         endcase
      end
   end

   // output serializer: byte 0 is on the port, shift down on each take
   always_comb begin
      run_valid_in  = run_valid_ff && !run_done;
      run_bytes_in  = run_bytes_ff;
      run_left_in   = run_left_ff;
      run_status_in = run_status_ff;
      if (run_load) begin
         run_valid_in  = 1'b1;
         run_bytes_in  = pend_bytes_ff;
         run_left_in   = pend_last_ff;
         run_status_in = pend_status_ff;
      end else if (rsp_take) begin
         run_bytes_in = {START_BYTE, run_bytes_ff[RunBytes-1:1]};
         run_left_in  = run_left_ff - run_idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff   <= '0;
         frame_open_ff  <= 1'b0;
         pixels_left_ff <= '0;
         pend_valid_ff  <= 1'b0;
         run_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            led_count_ff <= csr_led_count;
         end
         frame_open_ff  <= frame_open_in;
         pixels_left_ff <= pixels_left_in;
         pend_valid_ff  <= pend_valid_in;
         run_valid_ff   <= run_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_bytes_ff  <= pend_bytes_in;
      pend_last_ff   <= pend_last_in;
      pend_status_ff <= pend_status_in;
      run_bytes_ff   <= run_bytes_in;
      run_left_ff    <= run_left_in;
      run_status_ff  <= run_status_in;
   end

   assign rsp_valid       = run_valid_ff;
   assign rsp_spi_byte    = run_bytes_ff[0];
   assign rsp_status      = run_status_ff;
   assign rsp_last_of_run = (run_left_ff == LAST_OF_ONE);

`ifndef ASSERT_OFF
   a_closed_frame_empty: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> (pixels_left_ff == '0))
      else $error("pixels left while no frame is open");

   a_error_single_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last_of_run && (rsp_spi_byte == '0))
      else $error("error result is not a single zero byte");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      run_done && !pend_valid_ff |=> !rsp_valid)
      else $error("result valid after the run finished");

   a_stall_means_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> run_valid_ff && !run_done)
      else $error("input stalled while serializer is free");
`endif

endmodule
